@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/dcc_pkg.sv @@
package dcc_pkg;

    localparam int CW  = 32;            // coordinate width
    localparam int LW  = 31;            // limit register width
    localparam int MW  = CW + 1;        // link magnitude width
    localparam int PW  = 2 * MW;        // square width
    localparam int D2W = 2 * MW + 2;    // squared length width
    localparam int SQ  = D2W / 2;       // root bits, one per sqrt stage
    localparam int SW  = SQ;            // root width
    localparam int RW  = SW + 2;        // sqrt remainder width
    localparam int NW  = MW + LW;       // numerator width
    localparam int IW  = 4;             // config index width
    localparam int LAT = 3 + SQ + LW + 1;

    typedef enum logic [IW-1:0] {
        CFG_LIMIT_LENGTH = 4'd0,
        CFG_FIXED_SIDE   = 4'd1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic signed [CW-1:0] first_z;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] second_y;
        logic signed [CW-1:0] second_z;
    } t_in_word;

    typedef struct packed {
        logic signed [CW-1:0] new_x;
        logic signed [CW-1:0] new_y;
        logic signed [CW-1:0] new_z;
        logic                 moved;
    } t_out_word;

    // side data that rides along the pipeline
    typedef struct packed {
        logic                 gt;
        logic [2:0]           neg;
        logic [2:0][CW-1:0]   fix;
        logic [2:0][CW-1:0]   mov;
    } t_tag;

endpackage

@@ rtl/distance_constraint_clamp.sv @@
// stages from start to strobe: link vector, squares, squared length and compare, sqrt, divide, output register
// throughput: one word per cycle, busy is never raised; the receiver cannot stall
// the sqrt takes one root bit per stage (SQ stages), the divide one quotient bit per stage
// reset (synchronous, active low) clears valid bits and both config registers to zero
`include "assert_macros.svh"

module distance_constraint_clamp
    import dcc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  t_in_word        i_word,
    output logic            o_strobe,
    output t_out_word       o_word,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [IW-1:0]   i_cfg_index,
    input  logic [31:0]     i_cfg_data
);

    logic [LW-1:0]   r_limit;
    logic            r_fixed_side;
    logic [2*LW-1:0] r_lim_sq;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= '0;
            r_fixed_side <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LIMIT_LENGTH: r_limit      <= i_cfg_data[LW-1:0];
                CFG_FIXED_SIDE:   r_fixed_side <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim_sq <= (2*LW)'(r_limit) * (2*LW)'(r_limit);
    end

    // stage 1: link vector and magnitudes
    logic                 r1_vld;
    t_tag                 r1_tag;
    logic [2:0][MW-1:0]   r1_mag;
    logic signed [CW-1:0] in_f [3];
    logic signed [CW-1:0] in_s [3];
    logic signed [MW-1:0] link [3];

    always_comb begin
        in_f[0] = i_word.first_x;
        in_f[1] = i_word.first_y;
        in_f[2] = i_word.first_z;
        in_s[0] = i_word.second_x;
        in_s[1] = i_word.second_y;
        in_s[2] = i_word.second_z;
        for (int i = 0; i < 3; i++) begin
            link[i] = MW'(in_f[i]) - MW'(in_s[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else          r1_vld <= i_start;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_mag[i]     <= link[i][MW-1] ? MW'(-link[i]) : MW'(link[i]);
            r1_tag.neg[i] <= link[i][MW-1];
            r1_tag.fix[i] <= r_fixed_side ? in_s[i] : in_f[i];
            r1_tag.mov[i] <= r_fixed_side ? in_f[i] : in_s[i];
        end
        r1_tag.gt <= 1'b0;
    end

    // stage 2: squares and scaled numerators
    logic               r2_vld;
    t_tag               r2_tag;
    logic [2:0][PW-1:0] r2_sq;
    logic [2:0][NW-1:0] r2_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else          r2_vld <= r1_vld;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_sq[i]   <= PW'(r1_mag[i]) * PW'(r1_mag[i]);
            r2_prod[i] <= NW'(r1_mag[i]) * NW'(r_limit);
        end
        r2_tag <= r1_tag;
    end

    // stage 3: squared length and limit compare
    logic               r3_vld;
    t_tag               r3_tag;
    logic [D2W-1:0]     r3_d2;
    logic [2:0][NW-1:0] r3_prod;
    logic [D2W-1:0]     d2_sum;
    t_tag               tag3;

    assign d2_sum = D2W'(r2_sq[0]) + D2W'(r2_sq[1]) + D2W'(r2_sq[2]);

    always_comb begin
        tag3    = r2_tag;
        tag3.gt = d2_sum > D2W'(r_lim_sq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else          r3_vld <= r2_vld;
    end

    always_ff @(posedge i_clk) begin
        r3_d2      <= d2_sum;
        r3_prod    <= r2_prod;
        r3_tag     <= tag3;
    end

    // sqrt pipeline, two radicand bits per stage
    logic               sq_vld  [0:SQ];
    t_tag               sq_tag  [0:SQ];
    logic [D2W-1:0]     sq_d2   [0:SQ];
    logic [RW-1:0]      sq_rem  [0:SQ];
    logic [SW-1:0]      sq_root [0:SQ];
    logic [2:0][NW-1:0] sq_prod [0:SQ];

    assign sq_vld[0]  = r3_vld;
    assign sq_tag[0]  = r3_tag;
    assign sq_d2[0]   = r3_d2;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_prod[0] = r3_prod;

    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        logic [RW-1:0] sh;
        logic [RW-1:0] test;
        logic          ge;

        assign sh   = {sq_rem[k][RW-3:0], sq_d2[k][D2W-1 -: 2]};
        assign test = {sq_root[k], 2'b01};
        assign ge   = sh >= test;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) sq_vld[k+1] <= 1'b0;
            else          sq_vld[k+1] <= sq_vld[k];
        end

        always_ff @(posedge i_clk) begin
            sq_rem[k+1]  <= ge ? sh - test : sh;
            sq_root[k+1] <= {sq_root[k][SW-2:0], ge};
            sq_d2[k+1]   <= {sq_d2[k][D2W-3:0], 2'b00};
            sq_tag[k+1]  <= sq_tag[k];
            sq_prod[k+1] <= sq_prod[k];
        end
    end

    // divide pipeline, one quotient bit per stage, three lanes
    logic               dv_vld  [0:LW];
    t_tag               dv_tag  [0:LW];
    logic [SW-1:0]      dv_dist [0:LW];
    logic [2:0][SW-1:0] dv_rem  [0:LW];
    logic [2:0][LW-1:0] dv_num  [0:LW];
    logic [2:0][LW-1:0] dv_q    [0:LW];

    assign dv_vld[0]  = sq_vld[SQ];
    assign dv_tag[0]  = sq_tag[SQ];
    assign dv_dist[0] = sq_root[SQ];

    for (genvar i = 0; i < 3; i++) begin : g_div_in
        // quotient stays below 2^LW, so the top part is already below dist
        assign dv_rem[0][i] = SW'(sq_prod[SQ][i][NW-1:LW]);
        assign dv_num[0][i] = sq_prod[SQ][i][LW-1:0];
        assign dv_q[0][i]   = '0;
    end

    for (genvar j = 0; j < LW; j++) begin : g_div
        logic [2:0][SW:0] sh;
        logic [2:0]       ge;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                sh[i] = {dv_rem[j][i], dv_num[j][i][LW-1]};
                ge[i] = sh[i] >= {1'b0, dv_dist[j]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) dv_vld[j+1] <= 1'b0;
            else          dv_vld[j+1] <= dv_vld[j];
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                dv_rem[j+1][i] <= ge[i] ? SW'(sh[i] - {1'b0, dv_dist[j]}) : SW'(sh[i]);
                dv_num[j+1][i] <= {dv_num[j][i][LW-2:0], 1'b0};
                dv_q[j+1][i]   <= {dv_q[j][i][LW-2:0], ge[i]};
            end
            dv_dist[j+1] <= dv_dist[j];
            dv_tag[j+1]  <= dv_tag[j];
        end
    end

    // output stage: apply the offset and saturate, or pass the moving point through when not over the limit
    localparam int XW = CW + 2;
    localparam logic signed [XW-1:0] MAXV = XW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [XW-1:0] MINV = -MAXV - XW'(1);

    t_tag                 ft;
    logic signed [XW-1:0] s_off [3];
    logic signed [XW-1:0] p_sum [3];
    logic signed [CW-1:0] p_out [3];
    logic                 r_strobe;
    t_out_word            r_word;

    assign ft = dv_tag[LW];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_off[i] = ft.neg[i] ? -XW'(dv_q[LW][i]) : XW'(dv_q[LW][i]);
            p_sum[i] = r_fixed_side ? XW'(signed'(ft.fix[i])) + s_off[i]
                                    : XW'(signed'(ft.fix[i])) - s_off[i];
            if (!ft.gt)              p_out[i] = signed'(ft.mov[i]);
            else if (p_sum[i] > MAXV) p_out[i] = MAXV[CW-1:0];
            else if (p_sum[i] < MINV) p_out[i] = MINV[CW-1:0];
            else                     p_out[i] = p_sum[i][CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else          r_strobe <= dv_vld[LW];
    end

    always_ff @(posedge i_clk) begin
        r_word.new_x <= p_out[0];
        r_word.new_y <= p_out[1];
        r_word.new_z <= p_out[2];
        r_word.moved <= ft.gt;
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_word;

    `ASSERT_IMPL(a_strobe_from_start, i_clk, i_rst_n, o_strobe, $past(i_start, LAT))
    `ASSERT_IMPL(a_root_nonzero, i_clk, i_rst_n, sq_vld[SQ] && sq_tag[SQ].gt, sq_root[SQ] != '0)
    `ASSERT_IMPL(a_quot_fits, i_clk, i_rst_n, dv_vld[0] && dv_tag[0].gt,
        (dv_rem[0][0] < dv_dist[0]) && (dv_rem[0][1] < dv_dist[0])
        && (dv_rem[0][2] < dv_dist[0]))

endmodule

@@ tb/sv/tb_distance_constraint_clamp.sv @@
module tb_distance_constraint_clamp;
    import dcc_pkg::*;

    // tracks the tether settings and the positions expected back from the pipe
    class clamp_scoreboard;
        bit [LW-1:0] limit_len;
        bit          side;
        t_out_word   pending[$];
        int          errors;
        int          n_moved;
        int          n_checked;

        function automatic bit [63:0] root_floor(bit [127:0] v);
            bit [63:0]  r;
            bit [127:0] t;
            r = 0;
            for (int b = 40; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) begin
                    r = t[63:0];
                end
            end
            return r;
        endfunction

        function automatic bit [CW-1:0] clip(longint v);
            if (v > 64'sd2147483647) begin
                return 32'h7FFFFFFF;
            end
            if (v < -64'sd2147483648) begin
                return 32'h80000000;
            end
            return v[CW-1:0];
        endfunction

        function void note_input(t_in_word w);
            longint     a[3], b[3], lk[3], q, s, p;
            bit [127:0] mag[3], d2, lim, root_len;
            t_out_word  r;
            bit [CW-1:0] pos[3];
            a[0] = w.first_x;  a[1] = w.first_y;  a[2] = w.first_z;
            b[0] = w.second_x; b[1] = w.second_y; b[2] = w.second_z;
            d2  = 0;
            lim = limit_len;
            for (int i = 0; i < 3; i++) begin
                lk[i]  = a[i] - b[i];
                mag[i] = (lk[i] < 0) ? -lk[i] : lk[i];
                d2 += mag[i] * mag[i];
            end
            if (d2 > lim * lim) begin
                root_len = root_floor(d2);
                for (int i = 0; i < 3; i++) begin
                    q = (mag[i] * lim) / root_len;
                    s = (lk[i] < 0) ? -q : q;
                    p = side ? (b[i] + s) : (a[i] - s);
                    pos[i] = clip(p);
                end
                r.moved = 1'b1;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    pos[i] = side ? a[i][CW-1:0] : b[i][CW-1:0];
                end
                r.moved = 1'b0;
            end
            r.new_x = pos[0];
            r.new_y = pos[1];
            r.new_z = pos[2];
            pending.push_back(r);
        endfunction

        function void check_result(t_out_word got);
            t_out_word e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (got.moved) begin
                n_moved++;
            end
            if (got.new_x !== e.new_x) begin
                $display("%0t: new_x exp %h got %h", $time, e.new_x, got.new_x);
                errors++;
            end
            if (got.new_y !== e.new_y) begin
                $display("%0t: new_y exp %h got %h", $time, e.new_y, got.new_y);
                errors++;
            end
            if (got.new_z !== e.new_z) begin
                $display("%0t: new_z exp %h got %h", $time, e.new_z, got.new_z);
                errors++;
            end
            if (got.moved !== e.moved) begin
                $display("%0t: moved exp %b got %b", $time, e.moved, got.moved);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_start = 1'b0;
    t_in_word        i_word = '0;
    logic            i_cfg_valid = 1'b0;
    logic [IW-1:0]   i_cfg_index = '0;
    logic [31:0]     i_cfg_data = '0;
    logic            o_busy;
    logic            o_strobe;
    t_out_word       o_word;
    logic            o_cfg_ready;

    clamp_scoreboard sb = new();
    int              idle_cycles = 0;
    int              n_sent = 0;
    int              n_settings = 0;

    distance_constraint_clamp uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_word      (i_word),
        .o_strobe    (o_strobe),
        .o_word      (o_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                sb.note_input(i_word);
            end
            if (o_strobe) begin
                sb.check_result(o_word);
            end
            if ((i_start && !o_busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles > 4000) begin
                $display("timeout waiting for the pipeline");
                $display("FAILURE");
                $finish;
            end
        end
    end

    // valid stays up afterwards, the caller drops it
    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_LIMIT_LENGTH) begin
            sb.limit_len = data[LW-1:0];
        end else begin
            sb.side = data[0];
        end
    endtask

    // drain the pipe, then change the tether settings
    task automatic set_tether(logic [LW-1:0] len, bit side);
        i_start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
        // upper data bits are junk the block must ignore
        write_reg(CFG_LIMIT_LENGTH, {1'($urandom), len});
        write_reg(CFG_FIXED_SIDE, {31'($urandom), side});
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic send_word(t_in_word w);
        i_start <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_busy);
        n_sent++;
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [CW-1:0] edge_val();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'h0;
            3: return 32'hFFFFFFFF;
            4: return 32'h1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_word random_word(logic [LW-1:0] len);
        t_in_word w;
        logic [CW-1:0] d[3];
        int span;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1: ;
            2: begin
                w.first_x = edge_val(); w.first_y = edge_val(); w.first_z = edge_val();
                w.second_x = edge_val(); w.second_y = edge_val(); w.second_z = edge_val();
            end
            3: begin
                w.second_x = w.first_x; w.second_y = w.first_y; w.second_z = w.first_z;
            end
            4: begin
                // separation right at the limit along one axis
                w.second_y = w.first_y;
                w.second_z = w.first_z;
                w.second_x = w.first_x - len - $urandom_range(0, 1) + $urandom_range(0, 1);
            end
            default: begin
                // separation of the order of the limit, either side of it
                span = (len > 32'h3FFFFFFF) ? 32'h3FFFFFFF : len;
                for (int i = 0; i < 3; i++) begin
                    d[i] = $urandom_range(0, span + 2) * (($urandom_range(0, 1)) ? 1 : -1);
                end
                w.second_x = w.first_x - d[0];
                w.second_y = w.first_y - d[1];
                w.second_z = w.first_z - d[2];
            end
        endcase
        return w;
    endfunction

    initial begin
        logic [LW-1:0] len;
        t_in_word      w;
        int            burst;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero limit, both sides: any separation collapses onto the fixed body
        set_tether('0, 1'b0);
        send_word('0);
        send_word({32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        send_word({32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                   32'h80000000, 32'h7FFFFFFF, 32'h80000000});
        send_word({32'h00010000, 32'hFFFF0000, 32'h12345678,
                   32'h00010000, 32'hFFFF0000, 32'h12345678});
        set_tether('0, 1'b1);
        send_word({32'h80000000, 32'h80000000, 32'h80000000,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
        send_word({32'h00030000, 32'h00040000, 32'h0, 32'h0, 32'h0, 32'h0});
        send_word({32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        // largest limit: extreme corners, plus a link exactly at the limit
        set_tether(31'h7FFFFFFF, 1'b0);
        send_word({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h80000000, 32'h80000000, 32'h80000000});
        send_word({32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        send_word({32'h80000000, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h0, 32'h0});
        set_tether(31'h7FFFFFFF, 1'b1);
        send_word({32'h80000000, 32'h80000000, 32'h80000000,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
        send_word({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0,
                   32'h80000000, 32'h80000000, 32'h0});
        // unit tether, 3-4-5 triangle and exact-limit link
        set_tether(31'h00010000, 1'b0);
        send_word({32'h00030000, 32'h00040000, 32'h0, 32'h0, 32'h0, 32'h0});
        send_word({32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        send_word({32'h00010001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        send_word({32'hFFFD0000, 32'hFFFC0000, 32'h0, 32'h0, 32'h0, 32'h0});

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: len = '0;
                1: len = 31'h7FFFFFFF;
                2: len = $urandom_range(1, 255);
                3, 4: len = $urandom_range(1, 32'h00100000);
                5, 6: len = $urandom_range(32'h00100000, 32'h10000000);
                default: len = $urandom;
            endcase
            set_tether(len, ph[0]);
            for (int k = 0; k < 195; ) begin
                burst = $urandom_range(1, 40);
                for (int j = 0; j < burst && k < 195; j++, k++) begin
                    w = random_word(len);
                    send_word(w);
                end
                // some bursts run straight into the next one
                if ($urandom_range(0, 3) != 0) begin
                    pause($urandom_range(1, 12));
                end
            end
        end

        i_start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            sb.errors++;
        end
        $display("%0d words sent over %0d tether settings, %0d results checked, %0d clamped",
                 n_sent, n_settings, sb.n_checked, sb.n_moved);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ distance_constraint_clamp.f @@
+incdir+rtl
rtl/dcc_pkg.sv
rtl/distance_constraint_clamp.sv
tb/sv/tb_distance_constraint_clamp.sv
